// ----- design/pmmu_pkg.sv -----
`timescale 1ns / 1ps
package pmmu_pkg;

    // Default number of descriptors in each half of the table
    localparam int SET_ENTRIES_DEF = 2048;

    // Table offset bits 23..2 select a descriptor
    localparam int DIV_W  = 22;
    localparam int ADDR_W = 24;

    localparam logic [ADDR_W-1:0] SYS_LIMIT = 24'h800000;

    // Commands
    localparam logic [1:0] CMD_READ      = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_CHECK     = 2'd2;
    localparam logic [1:0] CMD_TRANSLATE = 2'd3;

    // Check verdicts
    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_ACCESS = 2'd1;
    localparam logic [1:0] VERDICT_OWNER  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_DONE
    } t_state;

    // Request to the index reduction unit
    typedef struct packed {
        logic start;
        logic sel_table;
    } t_mod_req;

endpackage

// ----- design/pmmu_req_if.sv -----
`timescale 1ns / 1ps
interface pmmu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [23:0] address;
    logic [15:0] write_data;
    logic        byte_access;
    logic        from_dma;
    logic        system_mode;
    logic        want_read;
    logic        want_write;
    logic        want_execute;

    modport source (
        output valid, command, address, write_data, byte_access, from_dma,
               system_mode, want_read, want_write, want_execute,
        input  ready
    );

    modport sink (
        input  valid, command, address, write_data, byte_access, from_dma,
               system_mode, want_read, want_write, want_execute,
        output ready
    );
endinterface

// ----- design/pmmu_rsp_if.sv -----
`timescale 1ns / 1ps
interface pmmu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [22:0] phys_address;
    logic [1:0]  verdict;

    modport source (
        output valid, read_data, phys_address, verdict,
        input  ready
    );

    modport sink (
        input  valid, read_data, phys_address, verdict,
        output ready
    );
endinterface

// ----- design/pmmu_mem.sv -----
`timescale 1ns / 1ps
module pmmu_mem #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [31:0]              i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [31:0]              o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/pmmu_idx_mod.sv -----
`timescale 1ns / 1ps
module pmmu_idx_mod #(
    parameter int SET_ENTRIES = pmmu_pkg::SET_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pmmu_pkg::t_mod_req                   i_req,
    input  logic [pmmu_pkg::DIV_W-1:0]           i_dividend,
    output logic                                 o_done,
    output logic [$clog2(2*SET_ENTRIES)-1:0]     o_rem
);
    import pmmu_pkg::*;

    localparam int D_PAGE  = SET_ENTRIES;
    localparam int D_TABLE = 2 * SET_ENTRIES;
    localparam int IW      = $clog2(D_TABLE);
    localparam bit IS_POW2 = (SET_ENTRIES & (SET_ENTRIES - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            // Power-of-two table: remainder is a mask
            logic          r_done;
            logic [IW-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_req.start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_req.start) begin
                    r_rem <= i_req.sel_table ? i_dividend[IW-1:0]
                                             : (i_dividend[IW-1:0] & IW'(D_PAGE - 1));
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_recip
            // Reciprocal multiply, three steps: quotient estimate (low by at
            // most one), remainder estimate, one compare and subtract.
            localparam int RW = IW + 1;
            localparam int MW = DIV_W - 3;
            localparam int PW = DIV_W + MW;
            localparam logic [MW-1:0] M_PAGE  = MW'((1 << DIV_W) / D_PAGE);
            localparam logic [MW-1:0] M_TABLE = MW'((1 << DIV_W) / D_TABLE);

            logic             r_v1;
            logic             r_v2;
            logic             r_done;
            logic             r_sel1;
            logic             r_sel2;
            logic [DIV_W-1:0] r_x1;
            logic [MW-1:0]    r_q;
            logic [RW-1:0]    r_est;
            logic [RW-1:0]    r_rem;
            logic [MW-1:0]    mult;
            logic [PW-1:0]    prod;
            logic [RW-1:0]    div_s2;
            logic [RW-1:0]    div_s3;
            logic [MW+RW-1:0] qc;

            always_comb begin
                mult   = i_req.sel_table ? M_TABLE : M_PAGE;
                prod   = {{MW{1'b0}}, i_dividend} * {{DIV_W{1'b0}}, mult};
                div_s2 = r_sel1 ? RW'(D_TABLE) : RW'(D_PAGE);
                div_s3 = r_sel2 ? RW'(D_TABLE) : RW'(D_PAGE);
                qc     = {{RW{1'b0}}, r_q} * {{MW{1'b0}}, div_s2};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1   <= 1'b0;
                    r_v2   <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_v1   <= i_req.start;
                    r_v2   <= r_v1;
                    r_done <= r_v2;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_req.start) begin
                    r_q    <= prod[PW-1:DIV_W];
                    r_x1   <= i_dividend;
                    r_sel1 <= i_req.sel_table;
                end
                if (r_v1) begin
                    r_est  <= r_x1[RW-1:0] - qc[RW-1:0];
                    r_sel2 <= r_sel1;
                end
                if (r_v2) begin
                    r_rem <= (r_est >= div_s3) ? (r_est - div_s3) : r_est;
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem[IW-1:0];
        end
    endgenerate

endmodule

// ----- design/paged_mmu_with_uid_check_top.sv -----
`timescale 1ns / 1ps
// Paged MMU with owner-id check. Holds 2*SET_ENTRIES 32-bit page descriptors
// (user half below, system half above) in one synchronous RAM and serves four
// commands: descriptor read, descriptor write (byte or word; ignored from DMA),
// access check (ok / access fault / owner fault) and translate (23-bit physical
// address, sets referenced and, on writes, altered). One command is in work at
// a time; the next transfer is taken while a finished result waits at the
// output register, and a command can finish only once that register is free.
// Commands that touch the table pass the index, read and done states; a check
// at or above 0x800000 and a DMA write go straight to the done state. When
// SET_ENTRIES is a power of two the descriptor index is a mask; otherwise it
// is reduced by a reciprocal multiply over three steps.
// The single RAM port pair sets the order: the read, then the
// read-modify-write back. After reset a clearing pass zeroes the table;
// input ready stays low meanwhile, map_id writes are taken at any time.
module paged_mmu_with_uid_check_top #(
    parameter int SET_ENTRIES = pmmu_pkg::SET_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    pmmu_req_if.sink   i_req,
    pmmu_rsp_if.source o_rsp
);
    import pmmu_pkg::*;

    localparam int DEPTH = 2 * SET_ENTRIES;
    localparam int IW    = $clog2(DEPTH);

    // control
    t_state r_state, n_state;
    logic [IW-1:0] r_clr_idx;
    logic [7:0]    r_map_id;

    // captured command
    logic [1:0]  r_cmd;
    logic [23:0] r_addr;
    logic [15:0] r_wdata;
    logic        r_byte;
    logic        r_sys;
    logic        r_wr;
    logic        r_ww;
    logic        r_wx;
    logic [IW-1:0] r_index;

    // finished result, and the output register
    logic [15:0] r_res_rdata;
    logic [22:0] r_res_phys;
    logic [1:0]  r_res_verdict;
    logic        r_out_valid;
    logic [15:0] r_out_rdata;
    logic [22:0] r_out_phys;
    logic [1:0]  r_out_verdict;

    logic in_xfer, fast_path, is_table_cmd, out_free, load_out;
    logic [1:0] fast_verdict;

    t_mod_req           mod_req;
    logic [DIV_W-1:0]   mod_dividend;
    logic               mod_done;
    logic [IW-1:0]      mod_rem;
    logic [IW-1:0]      lookup_idx;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr;
    logic [31:0]   mem_wdata, mem_rdata;

    // descriptor arithmetic in the read stage
    logic [15:0] cur_word, rd_val, new_word;
    logic [31:0] wr_desc, tr_desc;
    logic [7:0]  owner;
    logic        perm_hit;
    logic [1:0]  chk_verdict;

    // ---------------- handshake ----------------
    assign in_xfer   = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign is_table_cmd = (i_req.command == CMD_READ) || (i_req.command == CMD_WRITE);

    // Commands that never look at the table: DMA writes and checks in the
    // system-only region.
    always_comb begin
        fast_path    = 1'b0;
        fast_verdict = VERDICT_OK;
        if (i_req.command == CMD_WRITE && i_req.from_dma) begin
            fast_path = 1'b1;
        end else if (i_req.command == CMD_CHECK && i_req.address >= SYS_LIMIT) begin
            fast_path    = 1'b1;
            fast_verdict = i_req.system_mode ? VERDICT_OK : VERDICT_ACCESS;
        end
    end

    // Table offset uses bits 23..2; page commands use the 4 KiB page number
    assign mod_dividend = is_table_cmd ? i_req.address[23:2]
                                       : DIV_W'(i_req.address[23:12]);

    // Page commands in system mode land in the upper half
    assign lookup_idx = (r_sys && (r_cmd == CMD_CHECK || r_cmd == CMD_TRANSLATE))
                        ? (mod_rem + IW'(SET_ENTRIES)) : mod_rem;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == IW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = fast_path ? ST_DONE : ST_INDEX;
                end
            end
            ST_INDEX: begin
                if (mod_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        i_req.ready       = 1'b0;
        mod_req.start     = 1'b0;
        mod_req.sel_table = is_table_cmd;
        mem_re            = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = r_index;
        mem_wdata         = '0;
        load_out          = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
            end
            ST_IDLE: begin
                i_req.ready   = 1'b1;
                mod_req.start = i_req.valid && !fast_path;
            end
            ST_INDEX: begin
                mem_re = mod_done;
            end
            ST_READ: begin
                // reads and checks leave the table untouched
                mem_we    = (r_cmd == CMD_WRITE) || (r_cmd == CMD_TRANSLATE);
                mem_wdata = (r_cmd == CMD_WRITE) ? wr_desc : tr_desc;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_map_id  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cfg_we) begin
                r_map_id <= i_cfg_wdata;
            end
        end
    end

    // ---------------- command capture ----------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd   <= i_req.command;
            r_addr  <= i_req.address;
            r_wdata <= i_req.write_data;
            r_byte  <= i_req.byte_access;
            r_sys   <= i_req.system_mode;
            r_wr    <= i_req.want_read;
            r_ww    <= i_req.want_write;
            r_wx    <= i_req.want_execute;
        end
        if (mem_re) begin
            r_index <= lookup_idx;
        end
    end

    // ---------------- descriptor logic ----------------
    always_comb begin
        cur_word = r_addr[1] ? mem_rdata[31:16] : mem_rdata[15:0];

        // byte 0 of a word is the high byte
        if (r_byte) begin
            rd_val   = r_addr[0] ? {8'h00, cur_word[7:0]} : {8'h00, cur_word[15:8]};
            new_word = r_addr[0] ? {cur_word[15:8], r_wdata[7:0]}
                                 : {r_wdata[7:0], cur_word[7:0]};
        end else begin
            rd_val   = cur_word;
            new_word = r_wdata;
        end
        wr_desc = r_addr[1] ? {new_word, mem_rdata[15:0]} : {mem_rdata[31:16], new_word};

        // referenced always, altered on writes
        tr_desc = mem_rdata | {30'd0, 1'b1, r_ww};

        owner    = mem_rdata[15:8];
        perm_hit = (r_wr && mem_rdata[31]) || (r_ww && mem_rdata[30])
                   || (r_wx && mem_rdata[29]);
        // owner mismatch outranks disable bits; owner 0 reads as access fault
        if (!r_sys && owner != r_map_id) begin
            chk_verdict = (owner != 8'h00) ? VERDICT_OWNER : VERDICT_ACCESS;
        end else if (perm_hit) begin
            chk_verdict = VERDICT_ACCESS;
        end else begin
            chk_verdict = VERDICT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_xfer) begin
            r_res_rdata   <= '0;
            r_res_phys    <= '0;
            r_res_verdict <= fast_verdict;
        end else if (r_state == ST_READ) begin
            r_res_rdata   <= (r_cmd == CMD_READ) ? rd_val : 16'h0000;
            r_res_phys    <= (r_cmd == CMD_TRANSLATE) ? {mem_rdata[26:16], r_addr[11:0]}
                                                      : 23'd0;
            r_res_verdict <= (r_cmd == CMD_CHECK) ? chk_verdict : VERDICT_OK;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_rdata   <= r_res_rdata;
            r_out_phys    <= r_res_phys;
            r_out_verdict <= r_res_verdict;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_out_rdata;
    assign o_rsp.phys_address = r_out_phys;
    assign o_rsp.verdict      = r_out_verdict;

    // ---------------- submodules ----------------
    pmmu_idx_mod #(
        .SET_ENTRIES(SET_ENTRIES)
    ) u_idx_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mod_req),
        .i_dividend (mod_dividend),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    pmmu_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (lookup_idx),
        .o_rdata (mem_rdata)
    );

`ifndef ASSERT_OFF
    // index result only arrives while the sequencer waits for it
    a_mod_done_in_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == ST_INDEX))
        else $error("index unit finished outside index state");

    // descriptor reads and checks must never modify the table
    a_no_write_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && (r_cmd == CMD_READ || r_cmd == CMD_CHECK)) |-> !mem_we)
        else $error("table written by a read-only command");

    // a new result appears only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result presented without finishing a command");
`endif

endmodule

// ----- dv/pmmu_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the paged MMU: mirrors the descriptor table and map_id,
// predicts one result per request transfer and compares result transfers
// in order.
module pmmu_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    pmmu_req_if        i_req,
    pmmu_rsp_if        i_rsp,
    output int         o_fail_count,
    output int         o_pending
);
    import pmmu_pkg::*;

    localparam int          TABLE_ROWS     = 2 * SET_ENTRIES_DEF;
    localparam logic [31:0] DESC_NO_READ   = 32'h8000_0000;
    localparam logic [31:0] DESC_NO_WRITE  = 32'h4000_0000;
    localparam logic [31:0] DESC_NO_EXEC   = 32'h2000_0000;
    localparam logic [31:0] DESC_REFERENCED = 32'h0000_0002;
    localparam logic [31:0] DESC_ALTERED   = 32'h0000_0001;

    typedef struct packed {
        logic [1:0]  command;
        logic [23:0] address;
        logic [15:0] read_data;
        logic [22:0] phys_address;
        logic [1:0]  verdict;
    } t_mmu_result;

    logic [31:0] desc_mirror [TABLE_ROWS];
    logic [7:0]  map_id_mirror;
    t_mmu_result result_q [$];
    int          fails = 0;

    // descriptor row addressed by a table byte offset
    function automatic logic [11:0] offset_row(logic [23:0] off);
        int row;
        row = (int'(off) >> 2) % TABLE_ROWS;
        return row[11:0];
    endfunction

    // descriptor row of a virtual page, user or system half
    function automatic logic [11:0] page_row(logic [23:0] va, logic sys);
        int row;
        row = (int'(va) >> 12) % SET_ENTRIES_DEF;
        if (sys)
            row += SET_ENTRIES_DEF;
        return row[11:0];
    endfunction

    task automatic note_failure(string msg);
        fails++;
        if (fails <= 10)
            $display("[%0t] mismatch %0d: %s", $realtime, fails, msg);
    endtask

    task automatic predict_access();
        logic [1:0]  cmd;
        logic [23:0] a;
        logic [11:0] row;
        logic [31:0] d;
        logic [15:0] w;
        logic [31:0] need;
        logic [7:0]  owner;
        t_mmu_result r;
        cmd = i_req.command;
        a   = i_req.address;
        r   = '0;
        r.command = cmd;
        r.address = a;
        case (cmd)
            CMD_READ: begin
                d = desc_mirror[offset_row(a)];
                w = a[1] ? d[31:16] : d[15:0];
                if (!i_req.byte_access)
                    r.read_data = w;
                else
                    r.read_data = a[0] ? {8'h00, w[7:0]} : {8'h00, w[15:8]};
            end
            CMD_WRITE: begin
                if (!i_req.from_dma) begin
                    row = offset_row(a);
                    d   = desc_mirror[row];
                    w   = a[1] ? d[31:16] : d[15:0];
                    if (!i_req.byte_access)
                        w = i_req.write_data;
                    else if (a[0])
                        w = {w[15:8], i_req.write_data[7:0]};
                    else
                        w = {i_req.write_data[7:0], w[7:0]};
                    if (a[1])
                        d[31:16] = w;
                    else
                        d[15:0] = w;
                    desc_mirror[row] = d;
                end
            end
            CMD_CHECK: begin
                if (a >= SYS_LIMIT) begin
                    r.verdict = i_req.system_mode ? VERDICT_OK : VERDICT_ACCESS;
                end else begin
                    d     = desc_mirror[page_row(a, i_req.system_mode)];
                    need  = (i_req.want_read    ? DESC_NO_READ  : '0)
                          | (i_req.want_write   ? DESC_NO_WRITE : '0)
                          | (i_req.want_execute ? DESC_NO_EXEC  : '0);
                    owner = d[15:8];
                    // owner mismatch wins over the disable bits
                    if (!i_req.system_mode && owner != map_id_mirror)
                        r.verdict = (owner == 8'h00) ? VERDICT_ACCESS : VERDICT_OWNER;
                    else if ((d & need) != '0)
                        r.verdict = VERDICT_ACCESS;
                    else
                        r.verdict = VERDICT_OK;
                end
            end
            default: begin
                row = page_row(a, i_req.system_mode);
                d   = desc_mirror[row] | DESC_REFERENCED;
                if (i_req.want_write)
                    d = d | DESC_ALTERED;
                desc_mirror[row] = d;
                r.phys_address = {d[26:16], a[11:0]};
            end
        endcase
        result_q.push_back(r);
    endtask

    task automatic compare_result();
        t_mmu_result e;
        if (result_q.size() == 0) begin
            note_failure($sformatf("result with nothing outstanding (rd %h pa %h v %0d)",
                i_rsp.read_data, i_rsp.phys_address, i_rsp.verdict));
        end else begin
            e = result_q.pop_front();
            if (i_rsp.read_data !== e.read_data)
                note_failure($sformatf("cmd %0d @%h read_data exp %h got %h",
                    e.command, e.address, e.read_data, i_rsp.read_data));
            if (i_rsp.phys_address !== e.phys_address)
                note_failure($sformatf("cmd %0d @%h phys_address exp %h got %h",
                    e.command, e.address, e.phys_address, i_rsp.phys_address));
            if (i_rsp.verdict !== e.verdict)
                note_failure($sformatf("cmd %0d @%h verdict exp %0d got %0d",
                    e.command, e.address, e.verdict, i_rsp.verdict));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_ROWS; k++)
                desc_mirror[k] = '0;
            map_id_mirror = '0;
            result_q.delete();
        end else begin
            if (i_cfg_we)
                map_id_mirror = i_cfg_wdata;
            // older result leaves before the new request is queued
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1)
                compare_result();
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                predict_access();
        end
        o_pending    = result_q.size();
        o_fail_count = fails;
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the MMU testbench. Makes the stimulus, paces both channels and
// gives the verdict; prediction and compare live in pmmu_checker.
module tb_top;
    import pmmu_pkg::*;

    // Quiet-cycle limit; the post-reset clearing pass dominates.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 235;
    // sender waits for the pipe to empty this often inside a phase
    localparam int DRAIN_EVERY    = 120;
    // a generous tail catches stray results
    localparam int TAIL_CYCLES    = 30;
    localparam int POOL_SIZE      = 6;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HOLD
    } t_rx_mode;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic       rx_ready  = 1'b0;

    int fail_count;
    int pending;

    // sender pacing
    int burst_left = 0;
    // map_id as last programmed, used to build matching owner ids
    logic [7:0] cur_id = '0;
    // small page working set per phase so checks hit written descriptors
    logic [10:0] user_pool [POOL_SIZE];
    logic [10:0] sys_pool  [POOL_SIZE];

    // receiver pacing
    t_rx_mode rx_mode      = RX_FREE;
    int       rx_left      = 0;
    int       rx_phase     = 0;
    int       rx_sel       = 0;
    bit       rx_hold_done = 1'b0;

    pmmu_req_if req_if ();
    pmmu_rsp_if rsp_if ();

    assign rsp_if.ready = rx_ready;

    paged_mmu_with_uid_check_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    pmmu_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 clk = ~clk;

    // Receiver: segments of free flow, random stalls, a fixed duty pattern,
    // or a hold-off. The first result seen triggers one long hold-off so the
    // block backs up and drops its input ready while the sender keeps going.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_sel = $urandom_range(0, 19);
            if (!rx_hold_done && rsp_if.valid === 1'b1) begin
                rx_mode      = RX_HOLD;
                rx_left      = 160;
                rx_hold_done = 1'b1;
            end else if (rx_sel == 0) begin
                rx_mode = RX_HOLD;
                rx_left = $urandom_range(20, 60);
            end else if (rx_sel < 7) begin
                rx_mode = RX_FREE;
                rx_left = $urandom_range(10, 80);
            end else if (rx_sel < 14) begin
                rx_mode = RX_RANDOM;
                rx_left = $urandom_range(10, 80);
            end else begin
                rx_mode = RX_PERIODIC;
                rx_left = $urandom_range(10, 80);
            end
        end
        rx_left  = rx_left - 1;
        rx_phase = rx_phase + 1;
        case (rx_mode)
            RX_FREE:     rx_ready <= 1'b1;
            RX_RANDOM:   rx_ready <= ($urandom_range(0, 2) != 0);
            RX_PERIODIC: rx_ready <= ((rx_phase % 5) < 2);
            default:     rx_ready <= 1'b0;
        endcase
    end

    // Watchdog: counts cycles without any transfer on either channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // table byte offset: upper bits are don't-care, the row wraps at 4096
    function automatic logic [23:0] tbl_off(logic [11:0] row, logic hi_word, logic lo_byte,
                                            logic [9:0] upper);
        return {upper, row, hi_word, lo_byte};
    endfunction

    function automatic logic [23:0] vaddr(logic [10:0] vpn, logic [11:0] off);
        return {1'b0, vpn, off};
    endfunction

    // One request transfer. Called right after a falling edge, returns right
    // after the falling edge that follows acceptance. Valid stays high across
    // a burst; a new burst starts after a random gap.
    task automatic issue(input logic [1:0] cmd, input logic [23:0] addr,
                         input logic [15:0] wdata, input logic bytew, input logic dma,
                         input logic sys, input logic wr, input logic ww, input logic wx);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_if.command      <= cmd;
        req_if.address      <= addr;
        req_if.write_data   <= wdata;
        req_if.byte_access  <= bytew;
        req_if.from_dma     <= dma;
        req_if.system_mode  <= sys;
        req_if.want_read    <= wr;
        req_if.want_write   <= ww;
        req_if.want_execute <= wx;
        req_if.valid        <= 1'b1;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        @(negedge clk);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_map_id(input logic [7:0] id);
        cfg_wdata <= id;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_id     = id;
    endtask

    // One random phase under a fixed map_id. Most traffic targets a small page
    // set so writes build owners and permissions that later checks and
    // translates actually see; the rest goes anywhere.
    task automatic run_phase(input logic [7:0] id);
        int          vpn;
        int          sel;
        logic        sys;
        logic        hi_word;
        logic        lo_byte;
        logic        bytew;
        logic        top_half;
        logic [11:0] row;
        logic [15:0] word;
        logic [15:0] wdata;
        logic [23:0] addr;
        logic [7:0]  owner;
        logic [1:0]  cmd;
        drain();
        set_map_id(id);
        // keep the first and last page of each half in play
        user_pool[0] = '0;
        user_pool[1] = 11'h7FF;
        sys_pool[0]  = '0;
        sys_pool[1]  = 11'h7FF;
        for (int p = 2; p < POOL_SIZE; p++) begin
            user_pool[p] = 11'($urandom);
            sys_pool[p]  = 11'($urandom);
        end
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            sys = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 85)
                vpn = int'(sys ? sys_pool[$urandom_range(0, POOL_SIZE - 1)]
                               : user_pool[$urandom_range(0, POOL_SIZE - 1)]);
            else
                vpn = $urandom_range(0, SET_ENTRIES_DEF - 1);
            row      = sys ? 12'(vpn + SET_ENTRIES_DEF) : 12'(vpn);
            hi_word  = 1'($urandom_range(0, 1));
            lo_byte  = 1'($urandom_range(0, 1));
            bytew    = ($urandom_range(0, 99) < 35);
            top_half = ($urandom_range(0, 99) < 15);
            wdata    = 16'($urandom);
            sel      = $urandom_range(0, 99);
            if (sel < 30) begin
                cmd = CMD_WRITE;
                if (!hi_word) begin
                    // owner word: half the time the current id, some unowned, some foreign
                    sel = $urandom_range(0, 9);
                    if (sel < 5)
                        owner = cur_id;
                    else if (sel < 7)
                        owner = 8'h00;
                    else
                        owner = 8'($urandom);
                    word = {owner, 8'($urandom)};
                end else begin
                    // permission word: each disable bit set now and then
                    word     = 16'($urandom);
                    word[15] = ($urandom_range(0, 9) < 3);
                    word[14] = ($urandom_range(0, 9) < 3);
                    word[13] = ($urandom_range(0, 9) < 3);
                end
                if (bytew)
                    wdata = {wdata[15:8], lo_byte ? word[7:0] : word[15:8]};
                else
                    wdata = word;
                addr = tbl_off(row, hi_word, lo_byte, 10'($urandom));
            end else if (sel < 50) begin
                cmd  = CMD_READ;
                addr = tbl_off(row, hi_word, lo_byte, 10'($urandom));
            end else begin
                cmd  = (sel < 80) ? CMD_CHECK : CMD_TRANSLATE;
                addr = {top_half, 11'(vpn), 12'($urandom)};
            end
            issue(cmd, addr, wdata, bytew, ($urandom_range(0, 9) == 0), sys,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
            if (k % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain();
        end
    endtask

    initial begin
        req_if.valid        = 1'b0;
        req_if.command      = CMD_READ;
        req_if.address      = '0;
        req_if.write_data   = '0;
        req_if.byte_access  = 1'b0;
        req_if.from_dma     = 1'b0;
        req_if.system_mode  = 1'b0;
        req_if.want_read    = 1'b0;
        req_if.want_write   = 1'b0;
        req_if.want_execute = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        // map_id may be written during the clearing pass
        set_map_id(8'h3C);

        // Directed part. Args: cmd, addr, data, byte, dma, sys, r, w, x.
        // cleared table reads back zero
        issue(CMD_READ,  tbl_off(12'd0, 0, 0, 10'd0), 16'h0000, 0, 0, 0, 0, 0, 0);
        // page 3: read-disabled, ppn 0x2BC; owner byte and low byte by byte writes
        issue(CMD_WRITE, tbl_off(12'd3, 1, 0, 10'd0), 16'h9ABC, 0, 0, 0, 0, 0, 0);
        issue(CMD_WRITE, tbl_off(12'd3, 0, 0, 10'd0), 16'h773C, 1, 0, 0, 0, 0, 0);
        issue(CMD_WRITE, tbl_off(12'd3, 0, 1, 10'd0), 16'hAA40, 1, 0, 0, 0, 0, 0);
        issue(CMD_READ,  tbl_off(12'd3, 0, 0, 10'd0), 16'hFFFF, 0, 0, 0, 0, 0, 0);
        issue(CMD_READ,  tbl_off(12'd3, 1, 0, 10'd0), 16'h0000, 1, 0, 0, 0, 0, 0);
        issue(CMD_READ,  tbl_off(12'd3, 1, 1, 10'd0), 16'h0000, 1, 0, 0, 0, 0, 0);
        // DMA write must leave the table alone
        issue(CMD_WRITE, tbl_off(12'd3, 1, 0, 10'd0), 16'hFFFF, 0, 1, 0, 0, 0, 0);
        issue(CMD_READ,  tbl_off(12'd3, 1, 0, 10'd0), 16'h0000, 0, 0, 0, 0, 0, 0);
        // permission checks on an owned page
        issue(CMD_CHECK, vaddr(11'd3, 12'h123), 16'h0000, 0, 0, 0, 1, 0, 0);
        issue(CMD_CHECK, vaddr(11'd3, 12'h123), 16'h0000, 0, 0, 0, 0, 1, 1);
        issue(CMD_CHECK, vaddr(11'd3, 12'h123), 16'h0000, 0, 0, 0, 1, 1, 1);
        // unowned page in user mode is an access fault, foreign owner an owner fault
        issue(CMD_CHECK, vaddr(11'd7, 12'h000), 16'h0000, 0, 0, 0, 0, 0, 0);
        issue(CMD_WRITE, tbl_off(12'd9, 0, 0, 10'd0), 16'h7700, 0, 0, 0, 0, 0, 0);
        issue(CMD_CHECK, vaddr(11'd9, 12'hFFF), 16'h0000, 0, 0, 0, 0, 0, 0);
        // system-only space, then system half with no owner check
        issue(CMD_CHECK, 24'h800000, 16'h0000, 0, 0, 0, 0, 0, 0);
        issue(CMD_CHECK, 24'hFFFFFF, 16'h0000, 0, 0, 1, 1, 1, 1);
        issue(CMD_CHECK, vaddr(11'd3, 12'h000), 16'h0000, 0, 0, 1, 1, 1, 1);
        // translate sets referenced, then altered; DMA translate is normal
        issue(CMD_TRANSLATE, vaddr(11'd3, 12'hABC), 16'h0000, 0, 1, 0, 0, 0, 0);
        issue(CMD_TRANSLATE, vaddr(11'd3, 12'h001), 16'h0000, 0, 0, 0, 0, 1, 0);
        issue(CMD_READ,  tbl_off(12'd3, 0, 0, 10'd0), 16'h0000, 0, 0, 0, 0, 0, 0);
        // translate above the user space wraps the page number
        issue(CMD_TRANSLATE, 24'hFFFFFF, 16'h0000, 0, 0, 1, 1, 1, 1);
        issue(CMD_READ,  24'hFFFFFC, 16'h0000, 0, 0, 0, 0, 0, 0);
        // oversized table offset wraps onto page 3
        issue(CMD_WRITE, tbl_off(12'd3, 1, 0, 10'h3FF), 16'hE123, 0, 0, 0, 0, 0, 0);
        issue(CMD_CHECK, vaddr(11'd3, 12'h000), 16'h0000, 0, 0, 0, 0, 1, 0);
        issue(CMD_TRANSLATE, vaddr(11'd3, 12'h555), 16'h0000, 0, 0, 0, 0, 0, 0);

        // random phases, map_id extremes among them
        run_phase(8'hFF);
        run_phase(8'($urandom));
        run_phase(8'h00);
        run_phase(8'($urandom));
        run_phase(8'h01);
        run_phase(8'h80 | 8'($urandom));

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pmmu_pkg.sv
design/pmmu_req_if.sv
design/pmmu_rsp_if.sv
design/pmmu_mem.sv
design/pmmu_idx_mod.sv
design/paged_mmu_with_uid_check_top.sv
dv/pmmu_checker.sv
dv/tb_top.sv
